>>> src/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg
// Types, codes and address helpers for the bounding sphere transform.
// ----------------------------------------------------------------------------
package bst_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_FLUSH,
		ST_SUM,
		ST_MAX,
		ST_SQRT,
		ST_RMUL,
		ST_RFLUSH,
		ST_OUT
	} state_t;

	typedef logic [3:0] addr_t;

	localparam logic [2:0] CMD_TRANS  = 3'd3;
	localparam logic [2:0] CMD_SPHERE = 3'd4;

	localparam int unsigned MAT_DEPTH = 12;
	localparam int unsigned MAT_WIDTH = 32;

	// product groups: three center columns, six dot products, radius
	localparam logic [3:0] GRP_CEN_LAST  = 4'd2;
	localparam logic [3:0] GRP_DOT_FIRST = 4'd3;
	localparam logic [3:0] GRP_DOT_LAST  = 4'd8;
	localparam logic [3:0] GRP_RADIUS    = 4'd9;
	localparam logic [1:0] K_LAST        = 2'd2;

	function automatic addr_t row_addr(input logic [1:0] row, input logic [1:0] col);
		addr_t r;
		r = {2'b00, row};
		return (r << 1) + r + {2'b00, col};
	endfunction

	// port a: translation for center groups, row i for dot groups
	function automatic addr_t addr_a(input logic [3:0] grp, input logic [1:0] k);
		addr_t a;
		case (grp)
			4'd0, 4'd1, 4'd2: a = row_addr(2'd3, grp[1:0]);
			4'd3, 4'd6, 4'd7: a = row_addr(2'd0, k);
			4'd4, 4'd8:       a = row_addr(2'd1, k);
			4'd5:             a = row_addr(2'd2, k);
			default:          a = '0;
		endcase
		return a;
	endfunction

	// port b: basis column element for center groups, row j for dot groups
	function automatic addr_t addr_b(input logic [3:0] grp, input logic [1:0] k);
		addr_t b;
		case (grp)
			4'd0, 4'd1, 4'd2: b = row_addr(k, grp[1:0]);
			4'd3:             b = row_addr(2'd0, k);
			4'd4, 4'd6:       b = row_addr(2'd1, k);
			4'd5, 4'd7, 4'd8: b = row_addr(2'd2, k);
			default:          b = '0;
		endcase
		return b;
	endfunction

endpackage

>>> src/bst_in_if.sv
// ----------------------------------------------------------------------------
// bst_in_if
// Input channel: commands, matrix rows and spheres.
// ----------------------------------------------------------------------------
interface bst_in_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  cmd;
	logic signed [31:0] val_x;
	logic signed [31:0] val_y;
	logic signed [31:0] val_z;
	logic        [30:0] sphere_radius;

	modport source(output valid, cmd, val_x, val_y, val_z, sphere_radius, input ready);
	modport sink(input valid, cmd, val_x, val_y, val_z, sphere_radius, output ready);
endinterface

>>> src/bst_out_if.sv
// ----------------------------------------------------------------------------
// bst_out_if
// Result channel: transformed sphere and saturation flag.
// ----------------------------------------------------------------------------
interface bst_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic        [30:0] out_radius;
	logic               saturated;

	modport source(output valid, out_x, out_y, out_z, out_radius, saturated, input ready);
	modport sink(input valid, out_x, out_y, out_z, out_radius, saturated, output ready);
endinterface

>>> src/bst_ram.sv
// ----------------------------------------------------------------------------
// bst_ram
// Generic RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bst_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 12
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

>>> src/bst_sqrt.sv
// ----------------------------------------------------------------------------
// bst_sqrt
// Iterative 64-bit integer square root, one root bit per cycle, rounded up.
// ----------------------------------------------------------------------------
module bst_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] n,
	output logic        done,
	output logic [32:0] root_ceil
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  step_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [63:0] rad_q;
	logic [35:0] rem_t;
	logic [35:0] trial;
	logic        fits;

	assign rem_t = {rem_q, rad_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits  = rem_t >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			root_q <= '0;
			rad_q  <= n;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (fits) begin
				rem_q  <= 34'(rem_t - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_t[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	// exact root when nothing is left over
	assign root_ceil = {1'b0, root_q} + {32'd0, (rem_q != '0)};
	assign done      = done_q;

endmodule

>>> src/bounding_sphere_transform.sv
// ----------------------------------------------------------------------------
// bounding_sphere_transform
// Affine transform of a bounding sphere, signed Q16.16, saturating outputs.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  sphere   in   valid / ready  cmd, val_x, val_y, val_z, sphere_radius
//  result   out  valid / ready  out_x, out_y, out_z, out_radius, saturated
//
// a row load: accept plus three matrix writes; an unused cmd is only accepted
// a sphere needs 29 products on one shared 33x33 multiplier
// and a 32-step square root
// reset clears the matrix through per-entry valid bits, no clearing pass
// a finished result waits in the output register; a new item is taken meanwhile
// and a second result stalls only until the output register frees up
module bounding_sphere_transform (
	input logic      clk,
	input logic      arst_n,
	bst_in_if.sink   sphere,
	bst_out_if.source result
);

	bst_pkg::state_t state_q, state_d;

	logic               accept;
	logic        [2:0]  cmd_q;
	logic signed [31:0] vx_q, vy_q, vz_q;
	logic        [30:0] rad_q;
	logic        [1:0]  cnt_q;
	logic        [3:0]  grp_q;
	logic        [1:0]  k_q;
	logic               issue;

	logic               we;
	bst_pkg::addr_t     waddr, raddr_a, raddr_b;
	logic        [31:0] wdata, rd_a, rd_b;
	logic        [11:0] vbits_q;

	logic               vld_s1, va_s1, vb_s1;
	logic        [3:0]  grp_s1;
	logic        [1:0]  k_s1;
	logic signed [31:0] rda, rdb, vsel;
	logic signed [32:0] ma, mb;

	logic               vld_s2;
	logic        [3:0]  grp_s2;
	logic        [1:0]  k_s2;
	logic signed [65:0] prod_s2;
	logic signed [31:0] trans_s2;

	logic signed [65:0] acc_q, addend, acc_nx, cen_round, dot_abs;
	logic signed [66:0] cen_t;
	logic signed [31:0] cen_sat;
	logic               cen_clip;
	logic        [63:0] dot_c4;
	logic        [49:0] rad_rq;

	logic signed [31:0] cx_q, cy_q, cz_q;
	logic               sat_c_q;
	logic        [63:0] dot_q [6];
	logic        [63:0] rs0_q, rs1_q, rs2_q, smax;
	logic               big_q;
	logic        [33:0] stretch_q;
	logic        [30:0] rad_res_q;
	logic               sat_r_q;

	logic               sq_start, sq_done;
	logic        [63:0] sq_n;
	logic        [32:0] sq_root;

	logic               res_valid_q;
	logic               res_free;

	assign accept   = sphere.valid && sphere.ready;
	assign res_free = !res_valid_q || result.ready;

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bst_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		sphere.ready = 1'b0;
		we           = 1'b0;
		issue        = 1'b0;
		sq_start     = 1'b0;
		unique case (state_q)
			bst_pkg::ST_IDLE: begin
				sphere.ready = 1'b1;
				if (sphere.valid) begin
					if (sphere.cmd <= bst_pkg::CMD_TRANS) begin
						state_d = bst_pkg::ST_LOAD;
					end else if (sphere.cmd == bst_pkg::CMD_SPHERE) begin
						state_d = bst_pkg::ST_MUL;
					end
				end
			end
			bst_pkg::ST_LOAD: begin
				we = 1'b1;
				if (cnt_q == 2'd2) state_d = bst_pkg::ST_IDLE;
			end
			bst_pkg::ST_MUL: begin
				issue = 1'b1;
				if (grp_q == bst_pkg::GRP_DOT_LAST && k_q == bst_pkg::K_LAST) begin
					state_d = bst_pkg::ST_FLUSH;
				end
			end
			bst_pkg::ST_FLUSH: begin
				if (!vld_s1 && !vld_s2) state_d = bst_pkg::ST_SUM;
			end
			bst_pkg::ST_SUM: state_d = bst_pkg::ST_MAX;
			bst_pkg::ST_MAX: begin
				sq_start = 1'b1;
				state_d  = bst_pkg::ST_SQRT;
			end
			bst_pkg::ST_SQRT: begin
				if (sq_done) state_d = bst_pkg::ST_RMUL;
			end
			bst_pkg::ST_RMUL: begin
				issue = 1'b1;
				if (k_q == 2'd1) state_d = bst_pkg::ST_RFLUSH;
			end
			bst_pkg::ST_RFLUSH: begin
				if (!vld_s1 && !vld_s2) state_d = bst_pkg::ST_OUT;
			end
			bst_pkg::ST_OUT: begin
				if (res_free) state_d = bst_pkg::ST_IDLE;
			end
			default: state_d = bst_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbits_q     <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
			grp_q       <= '0;
			k_q         <= '0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			if (we) vbits_q[waddr] <= 1'b1;
			if (accept) begin
				cnt_q <= '0;
				grp_q <= '0;
				k_q   <= '0;
			end
			if (state_q == bst_pkg::ST_LOAD) cnt_q <= cnt_q + 2'd1;
			if (state_q == bst_pkg::ST_MUL) begin
				if (k_q == bst_pkg::K_LAST) begin
					k_q   <= '0;
					grp_q <= grp_q + 4'd1;
				end else begin
					k_q <= k_q + 2'd1;
				end
			end
			if (state_q == bst_pkg::ST_SQRT && sq_done) begin
				grp_q <= bst_pkg::GRP_RADIUS;
				k_q   <= '0;
			end
			if (state_q == bst_pkg::ST_RMUL) k_q <= k_q + 2'd1;
			if (state_q == bst_pkg::ST_OUT && res_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// ----------------------------------------------------------- matrix store
	assign waddr   = bst_pkg::row_addr(cmd_q[1:0], cnt_q);
	assign raddr_a = bst_pkg::addr_a(grp_q, k_q);
	assign raddr_b = bst_pkg::addr_b(grp_q, k_q);

	always_comb begin
		unique case (cnt_q)
			2'd0:    wdata = vx_q;
			2'd1:    wdata = vy_q;
			default: wdata = vz_q;
		endcase
	end

	bst_ram #(
		.WIDTH(bst_pkg::MAT_WIDTH),
		.DEPTH(bst_pkg::MAT_DEPTH)
	) u_mat (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	// ------------------------------------------------------- shared multiplier
	// entries never written read as zero
	assign rda = va_s1 ? rd_a : '0;
	assign rdb = vb_s1 ? rd_b : '0;

	always_comb begin
		unique case (k_s1)
			2'd0:    vsel = vx_q;
			2'd1:    vsel = vy_q;
			default: vsel = vz_q;
		endcase
	end

	always_comb begin
		if (grp_s1 <= bst_pkg::GRP_CEN_LAST) begin
			ma = 33'(vsel);
			mb = 33'(rdb);
		end else if (grp_s1 == bst_pkg::GRP_RADIUS) begin
			ma = {2'b00, rad_q};
			mb = (k_s1 == 2'd0) ? {1'b0, stretch_q[31:0]} : {31'd0, stretch_q[33:32]};
		end else begin
			ma = 33'(rda);
			mb = 33'(rdb);
		end
	end

	// ----------------------------------------------------------- accumulator
	assign addend = (grp_s2 == bst_pkg::GRP_RADIUS && k_s2 == 2'd1) ? (prod_s2 <<< 32) : prod_s2;
	assign acc_nx = ((k_s2 == 2'd0) ? 66'sd0 : acc_q) + addend;

	// center: round to nearest, ties up, then add translation and clip
	assign cen_round = (acc_nx + 66'sd32768) >>> 16;
	assign cen_t     = 67'(cen_round) + 67'(trans_s2);

	always_comb begin
		cen_clip = 1'b1;
		if (cen_t > 67'sd2147483647) begin
			cen_sat = 32'sh7fffffff;
		end else if (cen_t < -67'sd2147483648) begin
			cen_sat = 32'sh80000000;
		end else begin
			cen_sat  = cen_t[31:0];
			cen_clip = 1'b0;
		end
	end

	assign dot_abs = acc_nx[65] ? -acc_nx : acc_nx;
	assign dot_c4  = 64'((dot_abs >> 2) + 66'(|dot_abs[1:0]));
	assign rad_rq  = 50'((acc_nx >> 16) + 66'(|acc_nx[15:0]));

	// ---------------------------------------------------- stretch and root
	always_comb begin
		smax = rs0_q;
		if (rs1_q > smax) smax = rs1_q;
		if (rs2_q > smax) smax = rs2_q;
	end

	assign sq_n = (smax[63:62] != 2'b00) ? smax : (smax << 2);

	bst_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.n        (sq_n),
		.done     (sq_done),
		.root_ceil(sq_root)
	);

	// --------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= sphere.cmd;
			vx_q  <= sphere.val_x;
			vy_q  <= sphere.val_y;
			vz_q  <= sphere.val_z;
			rad_q <= sphere.sphere_radius;
		end
		grp_s1   <= grp_q;
		k_s1     <= k_q;
		va_s1    <= vbits_q[raddr_a];
		vb_s1    <= vbits_q[raddr_b];
		grp_s2   <= grp_s1;
		k_s2     <= k_s1;
		prod_s2  <= ma * mb;
		trans_s2 <= rda;

		if (vld_s2) begin
			acc_q <= acc_nx;
			if (k_s2 == bst_pkg::K_LAST && grp_s2 <= bst_pkg::GRP_CEN_LAST) begin
				unique case (grp_s2[1:0])
					2'd0: begin
						cx_q    <= cen_sat;
						sat_c_q <= cen_clip;
					end
					2'd1: begin
						cy_q    <= cen_sat;
						sat_c_q <= sat_c_q | cen_clip;
					end
					default: begin
						cz_q    <= cen_sat;
						sat_c_q <= sat_c_q | cen_clip;
					end
				endcase
			end
			if (k_s2 == bst_pkg::K_LAST && grp_s2 >= bst_pkg::GRP_DOT_FIRST
			    && grp_s2 <= bst_pkg::GRP_DOT_LAST) begin
				dot_q[3'(grp_s2 - bst_pkg::GRP_DOT_FIRST)] <= dot_c4;
			end
			if (k_s2 == 2'd1 && grp_s2 == bst_pkg::GRP_RADIUS) begin
				if (rad_rq > 50'h7fffffff) begin
					rad_res_q <= 31'h7fffffff;
					sat_r_q   <= 1'b1;
				end else begin
					rad_res_q <= rad_rq[30:0];
					sat_r_q   <= 1'b0;
				end
			end
		end

		// row sums of |A*A^T|: order is d0, d1, d2, c01, c02, c12
		if (state_q == bst_pkg::ST_SUM) begin
			rs0_q <= dot_q[0] + dot_q[3] + dot_q[4];
			rs1_q <= dot_q[1] + dot_q[3] + dot_q[5];
			rs2_q <= dot_q[2] + dot_q[4] + dot_q[5];
		end
		if (state_q == bst_pkg::ST_MAX) big_q <= (smax[63:62] != 2'b00);
		if (state_q == bst_pkg::ST_SQRT && sq_done) begin
			stretch_q <= big_q ? {sq_root, 1'b0} : {1'b0, sq_root};
		end

		if (state_q == bst_pkg::ST_OUT && res_free) begin
			result.out_x      <= cx_q;
			result.out_y      <= cy_q;
			result.out_z      <= cz_q;
			result.out_radius <= rad_res_q;
			result.saturated  <= sat_c_q | sat_r_q;
		end
	end

	assign result.valid = res_valid_q;

	// ------------------------------------------------------------- assertions
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		sphere.ready |-> (!vld_s1 && !vld_s2))
		else $error("multiplier pipeline busy while taking an item");

	a_sqrt_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> (state_q == bst_pkg::ST_SQRT))
		else $error("root finished outside the root wait");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == bst_pkg::ST_OUT))
		else $error("result raised without finishing a sphere");

	a_no_issue_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (!issue && !vld_s1 && !vld_s2))
		else $error("matrix write overlaps the product sequence");

endmodule
